// ----- src/mll_pkg.sv -----
// constants, types and tables shared by the ladder low-pass filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mll_pkg;

   // q4.28 tuning constants
   localparam logic signed [33:0] Q28_ONE = 34'sd268435456;
   localparam logic [28:0]        FN_MAX  = 29'd301989888;
   localparam logic signed [33:0] C_3P6   = 34'sd966367642;
   localparam logic signed [33:0] C_1P6   = 34'sd429496730;
   localparam logic signed [33:0] C_LN4   = 34'sd372118382;

   // exp table, steps of 1/8 from -1/8 to 3/2, q.16
   localparam int EXP_SEGS    = 13;
   localparam int EXP_STEP_SH = 25;
   localparam logic [18:0] EXP_TAB [EXP_SEGS + 1] = '{
      19'd57835,  19'd65536,  19'd74262,  19'd84150,  19'd95354,
      19'd108051, 19'd122437, 19'd138740, 19'd157213, 19'd178145,
      19'd201865, 19'd228743, 19'd259200, 19'd293712
   };

   // floor(2^34 / 6), reciprocal for the clipper's divide by six
   localparam logic [31:0] RECIP_SIX = 32'hAAAA_AAAA;

   // register map, index field is paddr[2]
   localparam logic CSR_CUTOFF_GAIN = 1'b0;
   localparam logic [31:0] CUTOFF_GAIN_RESET = 32'd159434;

   // sequencer steps, one multiply each
   typedef logic [4:0] step_type;
   localparam step_type ST_FN     = 5'd0;
   localparam step_type ST_T1     = 5'd1;
   localparam step_type ST_FN2    = 5'd2;
   localparam step_type ST_T2     = 5'd3;
   localparam step_type ST_ARG    = 5'd4;
   localparam step_type ST_SCALE  = 5'd5;
   localparam step_type ST_K      = 5'd6;
   localparam step_type ST_FB     = 5'd7;
   localparam step_type ST_POLE0  = 5'd8;
   localparam step_type ST_POLE_L = 5'd15;
   localparam step_type ST_Y2     = 5'd16;
   localparam step_type ST_Y3     = 5'd17;
   localparam step_type ST_DIV    = 5'd18;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_WB   = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ----- src/mll_if.sv -----
// stream channel interfaces for the ladder low-pass filter
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface mll_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample_in;
   logic        [16:0] cutoff_hz;
   logic        [15:0] resonance;
   modport source (output valid, sample_in, cutoff_hz, resonance, input ready);
   modport sink   (input valid, sample_in, cutoff_hz, resonance, output ready);
endinterface

interface mll_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

// ----- src/moog_ladder_lowpass_unit.sv -----
// four-pole ladder low-pass: each item is worked in 19 passes through one shared multiplier
// (operand select + multiply, then writeback); a new input is taken only when the sequencer
// is idle again, after the last result has been written; input is taken while a result waits
// reset (synchronous, active high) clears filter state, sequencer and output valid,
// and loads cutoff_gain with its reset default
`timescale 1ns / 1ps
`default_nettype none

module moog_ladder_lowpass_unit (
   input  wire         clock,
   input  wire         reset,
   mll_req_if.sink     req_bus,
   mll_rsp_if.source   rsp_bus,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic signed [67:0] I32_MAX = 68'sd2147483647;
   localparam logic signed [67:0] I32_MIN = -68'sd2147483648;
   localparam logic signed [35:0] U_MAX   =
      36'sd436207615; // 13 segments of 2^25, minus one

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > I32_MAX)      sat32 = 32'sh7FFF_FFFF;
      else if (v < I32_MIN) sat32 = 32'sh8000_0000;
      else                  sat32 = v[31:0];
   endfunction

   // sequencer
   mll_pkg::state_type state_ff, state_in;
   mll_pkg::step_type  step_ff, step_in;

   // captured item and config
   logic signed [23:0] smp_ff;
   logic        [16:0] hz_ff;
   logic        [15:0] res_ff;
   logic        [31:0] gain_ff;

   // shared multiplier
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p, prod_ff;

   // intermediates
   logic        [28:0] fn_ff, fn_in;
   logic signed [31:0] t1_ff, t1_in;
   logic        [29:0] fn2_ff, fn2_in;
   logic signed [31:0] kp_ff, kp_in, p_ff, p_in;
   logic        [3:0]  idx_ff, idx_in;
   logic        [24:0] frac_ff, frac_in;
   logic        [18:0] scale_ff, scale_in;
   logic        [18:0] k_ff, k_in;
   logic signed [31:0] xn_ff, xn_in;
   logic signed [67:0] acc_ff, acc_in;
   logic        [29:0] y2_ff, y2_in;
   logic               neg_ff, neg_in;
   logic        [32:0] mag_ff, mag_in;

   // filter state: stage outputs and previous stage inputs
   logic signed [31:0] stg_ff [4];
   logic signed [31:0] prv_ff [4];
   logic signed [31:0] stg_in [4];
   logic signed [31:0] prv_in [4];

   // output register
   logic               out_valid_ff, out_valid_in;
   logic signed [23:0] out_ff, out_in;

   // helpers
   logic        [4:0]  pole_off;
   logic        [1:0]  pole_j;
   logic               is_pole;
   logic signed [31:0] pole_x;
   logic signed [26:0] y_val;
   logic               out_free;
   logic               csr_wr;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign pole_off = step_ff - mll_pkg::ST_POLE0;
   assign pole_j   = pole_off[2:1];
   assign is_pole  = step_ff inside {[mll_pkg::ST_POLE0:mll_pkg::ST_POLE_L]};
   assign pole_x   = (pole_j == 2'd0) ? xn_ff : stg_ff[2'(pole_j - 2'd1)];
   assign y_val    = stg_ff[3][31:5]; // q.23 view of the last stage

   // handshake and config port
   assign req_bus.ready      = (state_ff == mll_pkg::S_IDLE);
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.sample_out = out_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == mll_pkg::CSR_CUTOFF_GAIN) ? gain_ff : 32'd0;

   // operand select for the one multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (is_pole) begin
         if (!pole_off[0]) begin
            // (x + x_prev) * p
            mul_a = 34'(pole_x) + 34'(prv_ff[pole_j]);
            mul_b = 34'(p_ff);
         end else begin
            // kp * y_old
            mul_a = 34'(kp_ff);
            mul_b = 34'(stg_ff[pole_j]);
         end
      end else begin
         case (step_ff)
            mll_pkg::ST_FN: begin
               mul_a = $signed({17'd0, hz_ff});
               mul_b = $signed({2'd0, gain_ff});
            end
            mll_pkg::ST_T1: begin
               mul_a = mll_pkg::C_3P6;
               mul_b = $signed({5'd0, fn_ff});
            end
            mll_pkg::ST_FN2: begin
               mul_a = $signed({5'd0, fn_ff});
               mul_b = $signed({5'd0, fn_ff});
            end
            mll_pkg::ST_T2: begin
               mul_a = mll_pkg::C_1P6;
               mul_b = $signed({4'd0, fn2_ff});
            end
            mll_pkg::ST_ARG: begin
               mul_a = mll_pkg::Q28_ONE - 34'(p_ff);
               mul_b = mll_pkg::C_LN4;
            end
            mll_pkg::ST_SCALE: begin
               mul_a = $signed({15'd0, mll_pkg::EXP_TAB[4'(idx_ff + 4'd1)]})
                     - $signed({15'd0, mll_pkg::EXP_TAB[idx_ff]});
               mul_b = $signed({9'd0, frac_ff});
            end
            mll_pkg::ST_K: begin
               mul_a = $signed({18'd0, res_ff});
               mul_b = $signed({15'd0, scale_ff});
            end
            mll_pkg::ST_FB: begin
               mul_a = $signed({15'd0, k_ff});
               mul_b = 34'(stg_ff[3]);
            end
            mll_pkg::ST_Y2: begin
               mul_a = 34'(y_val);
               mul_b = 34'(y_val);
            end
            mll_pkg::ST_Y3: begin
               mul_a = $signed({4'd0, y2_ff});
               mul_b = 34'(y_val);
            end
            mll_pkg::ST_DIV: begin
               mul_a = $signed({1'b0, mag_ff});
               mul_b = $signed({2'd0, mll_pkg::RECIP_SIX});
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;

   // writeback of each product and sequencing
   always_comb begin
      logic signed [31:0] t2;
      logic signed [31:0] kpp;
      logic signed [35:0] u;
      logic signed [67:0] v;
      logic        [32:0] q;
      logic        [35:0] r;
      logic signed [33:0] c;
      logic signed [33:0] y3;
      logic signed [34:0] o;

      state_in     = state_ff;
      step_in      = step_ff;
      fn_in        = fn_ff;
      t1_in        = t1_ff;
      fn2_in       = fn2_ff;
      kp_in        = kp_ff;
      p_in         = p_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      scale_in     = scale_ff;
      k_in         = k_ff;
      xn_in        = xn_ff;
      acc_in       = acc_ff;
      y2_in        = y2_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      stg_in       = stg_ff;
      prv_in       = prv_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      t2  = '0;
      kpp = '0;
      u   = '0;
      v   = '0;
      q   = '0;
      r   = '0;
      c   = '0;
      y3  = '0;
      o   = '0;

      case (state_ff)
         mll_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               state_in = mll_pkg::S_MUL;
               step_in  = mll_pkg::ST_FN;
            end
         end
         mll_pkg::S_MUL: begin
            state_in = mll_pkg::S_WB;
         end
         mll_pkg::S_WB: begin
            state_in = mll_pkg::S_MUL;
            step_in  = step_ff + 5'd1;
            if (is_pole) begin
               if (!pole_off[0]) begin
                  acc_in = prod_ff;
               end else begin
                  // stage output, then its input becomes x_prev
                  v = (acc_ff - prod_ff) >>> 28;
                  stg_in[pole_j] = sat32(v);
                  prv_in[pole_j] = pole_x;
               end
            end else begin
               case (step_ff)
                  mll_pkg::ST_FN: begin
                     // clamp to the top of the tuning curve
                     if (prod_ff[67:4] > 64'(mll_pkg::FN_MAX)) fn_in = mll_pkg::FN_MAX;
                     else                                       fn_in = prod_ff[32:4];
                  end
                  mll_pkg::ST_T1: t1_in = prod_ff[59:28];
                  mll_pkg::ST_FN2: fn2_in = prod_ff[57:28];
                  mll_pkg::ST_T2: begin
                     t2    = prod_ff[59:28];
                     kpp   = t1_ff - t2;
                     kp_in = kpp - 32'(mll_pkg::Q28_ONE);
                     p_in  = (kpp < 0) ? 32'sd0 : (kpp >>> 1);
                  end
                  mll_pkg::ST_ARG: begin
                     u = prod_ff[63:28] + 36'sd33554432;
                     if (u < 0)          u = '0;
                     else if (u > U_MAX) u = U_MAX;
                     idx_in  = u[28:25];
                     frac_in = u[24:0];
                  end
                  mll_pkg::ST_SCALE: begin
                     scale_in = mll_pkg::EXP_TAB[idx_ff] + prod_ff[43:25];
                  end
                  mll_pkg::ST_K: k_in = prod_ff[34:16];
                  mll_pkg::ST_FB: begin
                     // input scaled to q4.28 minus resonance feedback
                     v = (68'(smp_ff) <<< 5) - (prod_ff >>> 14);
                     xn_in = sat32(v);
                  end
                  mll_pkg::ST_Y2: y2_in = prod_ff[52:23];
                  mll_pkg::ST_Y3: begin
                     y3     = prod_ff[56:23];
                     neg_in = y3[33];
                     mag_in = y3[33] ? 33'(-y3) : 33'(y3);
                  end
                  mll_pkg::ST_DIV: begin
                     // reciprocal estimate is low by at most one
                     q = prod_ff[66:34];
                     r = {3'd0, mag_ff} - (({3'd0, q}) << 2) - (({3'd0, q}) << 1);
                     if (r >= 36'd6) q = q + 33'd1;
                     c = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
                     o = 35'(y_val) - 35'(c);
                     if (out_free) begin
                        state_in     = mll_pkg::S_IDLE;
                        step_in      = step_ff;
                        out_valid_in = 1'b1;
                        if (o > 35'sd8388607)       out_in = 24'sh7F_FFFF;
                        else if (o < -35'sd8388608) out_in = 24'sh80_0000;
                        else                        out_in = o[23:0];
                     end else begin
                        state_in = mll_pkg::S_WB;
                        step_in  = step_ff;
                     end
                  end
                  default: begin
                     state_in = mll_pkg::S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = mll_pkg::S_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mll_pkg::S_IDLE;
         step_ff      <= mll_pkg::ST_FN;
         out_valid_ff <= 1'b0;
         gain_ff      <= mll_pkg::CUTOFF_GAIN_RESET;
         for (int i = 0; i < 4; i++) begin
            stg_ff[i] <= '0;
            prv_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         stg_ff       <= stg_in;
         prv_ff       <= prv_in;
         if (csr_wr && csr_paddr[2] == mll_pkg::CSR_CUTOFF_GAIN) begin
            gain_ff <= csr_pwdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         smp_ff <= req_bus.sample_in;
         hz_ff  <= req_bus.cutoff_hz;
         res_ff <= req_bus.resonance;
      end
      if (state_ff == mll_pkg::S_MUL) begin
         prod_ff <= mul_p;
      end
      fn_ff    <= fn_in;
      t1_ff    <= t1_in;
      fn2_ff   <= fn2_in;
      kp_ff    <= kp_in;
      p_ff     <= p_in;
      idx_ff   <= idx_in;
      frac_ff  <= frac_in;
      scale_ff <= scale_in;
      k_ff     <= k_in;
      xn_ff    <= xn_in;
      acc_ff   <= acc_in;
      y2_ff    <= y2_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      out_ff   <= out_in;
   end

endmodule

`default_nettype wire
